/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL
// Concurrent checks clocked on clock and switched off during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define STIS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define STIS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/stis_pkg.sv */
// ---------------------------------------------------------------------------
// stis_pkg
// Types and codes shared by the sorted table core and its cells.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stis_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int VALUE_W       = 32;
   localparam int COUNT_OUT_W   = 7;
   localparam int STATUS_W      = 2;

   // Operation codes carried in tuser
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

   // Broadcast from the controller to every cell
   typedef struct packed {
      logic                       ins;
      logic                       rem;
      logic signed [VALUE_W-1:0]  value;
   } cmd_type;

endpackage

`default_nettype wire

/* rtl/stis_cell.sv */
// ---------------------------------------------------------------------------
// stis_cell
// One slot of the sorted chain: holds a value and its valid bit, compares
// against the broadcast value, and takes from its left or right neighbour or the broadcast value.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stis_cell (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire stis_pkg::cmd_type                    cmd,
   input  wire logic                                 left_valid,
   input  wire logic                                 left_less,
   input  wire logic signed [stis_pkg::VALUE_W-1:0]  left_value,
   input  wire logic                                 right_valid,
   input  wire logic signed [stis_pkg::VALUE_W-1:0]  right_value,
   output logic                                      valid,
   output logic                                      less,
   output logic                                      eq,
   output logic signed [stis_pkg::VALUE_W-1:0]       value
);

   logic                                 valid_ff;
   logic                                 valid_in;
   logic signed [stis_pkg::VALUE_W-1:0]  value_ff;
   logic signed [stis_pkg::VALUE_W-1:0]  value_in;
   logic                                 lt;
   logic                                 ge;

   // Compare against the broadcast value
   assign lt    = value_ff < cmd.value;
   assign ge    = valid_ff && !lt;
   assign less  = valid_ff && lt;
   assign eq    = valid_ff && (value_ff == cmd.value);
   assign valid = valid_ff;
   assign value = value_ff;

   // Shift right on insert, shift left on remove, else hold
   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (cmd.ins) begin
         valid_in = valid_ff | left_valid;
         if (left_valid && !left_less) begin
            value_in = left_value;
         end else if (left_valid && (!valid_ff || ge)) begin
            value_in = cmd.value;
         end
      end else if (cmd.rem) begin
         if (ge) begin
            valid_in = right_valid;
            value_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

`default_nettype wire

/* rtl/sorted_table_insert_remove_core.sv */
// A sorted table of up to DEPTH signed 32-bit values kept in a chain of
// cells, smallest at the head. Each beat on req_ inserts (tuser 0) or
// removes the first equal value (tuser 1); each gives one result beat on
// rsp_ with status, count, smallest, largest and a nonempty flag. A beat
// is first captured, then every cell compares against the broadcast value
// and shifts in parallel; the result is loaded into the output register at
// the first edge at which the next beat can be accepted. No beat is taken
// while one is being applied; otherwise a held result stalls the input
// only when a further result is ready to leave.
// ---------------------------------------------------------------------------
// sorted_table_insert_remove_core
// Top level: beat capture, cell chain, status and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sorted_table_insert_remove_core #(
   parameter int DEPTH = stis_pkg::DEPTH_DEFAULT
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [31:0]   req_tdata,   // [31:0] value
   input  wire logic          req_tuser,   // [0] kind
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [79:0]        rsp_tdata    // [1:0] status, [8:2] entry_count,
                                           // [40:9] smallest, [72:41] largest,
                                           // [73] nonempty, [79:74] zero
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int VW    = stis_pkg::VALUE_W;
   localparam int OW    = stis_pkg::COUNT_OUT_W;

   // Command and control registers
   logic                            apply_ff;
   logic                            pend_ff;
   logic                            kind_ff;
   logic signed [VW-1:0]            value_ff;
   logic [CNT_W-1:0]                cnt_ff;
   logic [CNT_W-1:0]                cnt_in;
   logic [stis_pkg::STATUS_W-1:0]   status_ff;
   logic [stis_pkg::STATUS_W-1:0]   status_in;
   logic                            rsp_tvalid_ff;
   logic [79:0]                     rsp_tdata_ff;

   logic                            req_accept;
   logic                            slot_free;
   logic                            report;
   stis_pkg::cmd_type               cmd;

   // Chain signals
   logic [DEPTH-1:0]                valid_vec;
   logic [DEPTH-1:0]                less_vec;
   logic [DEPTH-1:0]                eq_vec;
   logic signed [VW-1:0]            value_arr [DEPTH];

   logic                            full;
   logic                            any_eq;
   logic signed [VW-1:0]            largest;
   logic signed [VW-1:0]            smallest;
   logic [CNT_W+OW-1:0]             cnt_ext;

   // Check terms
   int                              valid_ones;
   logic                            ins_refused;

   // Handshake
   assign slot_free  = !rsp_tvalid_ff || rsp_tready;
   assign report     = pend_ff && slot_free;
   assign req_tready = !apply_ff && (!pend_ff || slot_free);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Table-wide reductions
   assign full   = valid_vec[DEPTH-1];
   assign any_eq = |eq_vec;

   // Broadcast command, gated so refused operations leave the chain alone
   always_comb begin
      cmd.value = value_ff;
      cmd.ins   = apply_ff && (kind_ff == stis_pkg::KIND_INSERT) && !full;
      cmd.rem   = apply_ff && (kind_ff == stis_pkg::KIND_REMOVE) && any_eq;
   end

   // Cell chain
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                 lv;
      logic                 ll;
      logic signed [VW-1:0] lval;
      logic                 rv;
      logic signed [VW-1:0] rval;

      if (i == 0) begin : g_head
         assign lv   = 1'b1;
         assign ll   = 1'b1;
         assign lval = '0;
      end else begin : g_body
         assign lv   = valid_vec[i-1];
         assign ll   = less_vec[i-1];
         assign lval = value_arr[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign rv   = 1'b0;
         assign rval = '0;
      end else begin : g_inner
         assign rv   = valid_vec[i+1];
         assign rval = value_arr[i+1];
      end

      stis_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_valid  (lv),
         .left_less   (ll),
         .left_value  (lval),
         .right_valid (rv),
         .right_value (rval),
         .valid       (valid_vec[i]),
         .less        (less_vec[i]),
         .eq          (eq_vec[i]),
         .value       (value_arr[i])
      );
   end

   // Status and count of the operation being applied
   always_comb begin
      status_in = stis_pkg::ST_OK;
      cnt_in    = cnt_ff;
      if (cmd.ins) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (cmd.rem) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
      if (kind_ff == stis_pkg::KIND_INSERT) begin
         if (full) begin
            status_in = stis_pkg::ST_FULL;
         end
      end else if (!any_eq) begin
         status_in = stis_pkg::ST_NOT_FOUND;
      end
   end

   // Pick the last valid cell as the largest value
   always_comb begin
      largest = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (valid_vec[i] && ((i == DEPTH - 1) || !valid_vec[(i + 1) % DEPTH])) begin
            largest = largest | value_arr[i];
         end
      end
   end

   assign smallest = valid_vec[0] ? value_arr[0] : '0;
   assign cnt_ext  = {{OW{1'b0}}, cnt_ff};

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         apply_ff      <= 1'b0;
         pend_ff       <= 1'b0;
         cnt_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         apply_ff <= req_accept;
         if (apply_ff) begin
            pend_ff <= 1'b1;
            cnt_ff  <= cnt_in;
         end else if (report) begin
            pend_ff <= 1'b0;
         end
         if (report) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         kind_ff  <= req_tuser;
         value_ff <= req_tdata;
      end
      if (apply_ff) begin
         status_ff <= status_in;
      end
      if (report) begin
         rsp_tdata_ff <= {6'b0, valid_vec[0], largest, smallest,
                          cnt_ext[OW-1:0], status_ff};
      end
   end

   assign valid_ones  = $countones(valid_vec);
   assign ins_refused = apply_ff && (kind_ff == stis_pkg::KIND_INSERT) && full;

   // The number of set valid bits equals the count
   `STIS_ASSERT_NOW(a_count_matches, 1'b1, (valid_ones == int'(cnt_ff)), "count mismatch")
   // An applied operation always leaves a result to report
   `STIS_ASSERT_NEXT(a_apply_reports, apply_ff, pend_ff, "applied operation lost its result")
   // A refused insert leaves the count alone
   `STIS_ASSERT_NEXT(a_full_holds, ins_refused, $stable(cnt_ff), "refused insert changed count")

endmodule

`default_nettype wire
